### hdl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Holds the command codes, field widths and the store control struct.
// No dependencies.
package deq_pkg;

    localparam int DEPTH_DEF   = 1024;
    localparam int VALUE_W     = 10;
    localparam int CMD_W       = 3;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_PEEK_FRONT = 3'd2,
        CMD_PEEK_BACK  = 3'd3,
        CMD_POP_BACK   = 3'd4,
        CMD_POP_FRONT  = 3'd5
    } t_cmd;

    typedef struct packed {
        logic wr;
        logic rd;
    } t_mem_op;

endpackage

### hdl/deq_store.sv
// Entry store of the double-ended queue: one synchronous memory.
// One access per cycle, read data registered.
// Depends on deq_pkg.
module deq_store #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  deq_pkg::t_mem_op             i_op,
    input  logic [AW-1:0]                i_addr,
    input  logic [deq_pkg::VALUE_W-1:0]  i_wdata,
    output logic [deq_pkg::VALUE_W-1:0]  o_rdata
);

    logic [deq_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [deq_pkg::VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_op.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_op.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/double_ended_queue.sv
// Top level of the bounded double-ended queue (ring store, front pointer, count).
// Instantiates deq_store for the entries; uses deq_pkg for codes and widths.
//
//  channel  dir  tdata                        tuser
//  s        in   [9:0] value, rest zero       [2:0] command
//  m        out  [9:0] peek_value, rest zero  [0] is_none
//
// One command is taken per cycle while o_s_tready is high. A peek result
// passes through the store read register, then the output register. Reset
// clears the pointer, the count, the pending and the output valid flags;
// store contents stay undefined, with no clearing pass. o_s_tready drops
// only while a read result waits and the output register is stalled.
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [deq_pkg::IN_TDATA_W-1:0]  i_s_tdata,  // [9:0] value
    input  logic [deq_pkg::CMD_W-1:0]       i_s_tuser,  // [2:0] command
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [deq_pkg::OUT_TDATA_W-1:0] o_m_tdata,  // [9:0] peek_value
    output logic                            o_m_tuser   // [0] is_none
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [AW-1:0]                r_front, n_front;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic                         r_pend, r_pend_none;
    logic                         r_out_vld, r_out_none;
    logic [deq_pkg::VALUE_W-1:0]  r_out_data;

    logic                         accept, out_free, empty, full, peek;
    logic [CW-1:0]                offset;
    logic [SW-1:0]                sum, pos;
    logic [AW-1:0]                addr;
    deq_pkg::t_mem_op             mem_op;
    logic [deq_pkg::VALUE_W-1:0]  value, rdata;
    deq_pkg::t_cmd                cmd;

    assign out_free   = !r_out_vld || i_m_tready;
    assign o_s_tready = !(r_pend && !out_free);
    assign accept     = i_s_tvalid && o_s_tready;
    assign empty      = (r_cnt == '0);
    assign full       = (r_cnt == CW'(DEPTH));
    assign cmd        = deq_pkg::t_cmd'(i_s_tuser);
    assign value      = i_s_tdata[deq_pkg::VALUE_W-1:0];

    // back entry sits count-1 places after the front; a push back goes one further
    assign offset = (cmd == deq_pkg::CMD_PUSH_BACK) ? r_cnt : r_cnt - CW'(1);
    assign sum    = {1'b0, r_front} + SW'(offset);
    assign pos    = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;

    always_comb begin
        n_front = r_front;
        n_cnt   = r_cnt;
        addr    = pos[AW-1:0];
        mem_op  = '0;
        peek    = 1'b0;
        unique case (cmd)
            deq_pkg::CMD_PUSH_BACK: begin
                if (!full) begin
                    mem_op.wr = accept;
                    n_cnt     = r_cnt + CW'(1);
                end
            end
            deq_pkg::CMD_PUSH_FRONT: begin
                if (!full) begin
                    n_front   = (r_front == '0) ? LAST_IDX : r_front - AW'(1);
                    addr      = n_front;
                    mem_op.wr = accept;
                    n_cnt     = r_cnt + CW'(1);
                end
            end
            deq_pkg::CMD_PEEK_FRONT: begin
                addr      = r_front;
                peek      = 1'b1;
                mem_op.rd = accept && !empty;
            end
            deq_pkg::CMD_PEEK_BACK: begin
                peek      = 1'b1;
                mem_op.rd = accept && !empty;
            end
            deq_pkg::CMD_POP_BACK: begin
                if (!empty) begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            deq_pkg::CMD_POP_FRONT: begin
                if (!empty) begin
                    n_front = (r_front == LAST_IDX) ? '0 : r_front + AW'(1);
                    n_cnt   = r_cnt - CW'(1);
                end
            end
            default: begin
                // unused codes: drop
            end
        endcase
    end

    deq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_op    (mem_op),
        .i_addr  (addr),
        .i_wdata (value),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front   <= '0;
            r_cnt     <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_front <= n_front;
                r_cnt   <= n_cnt;
            end
            if (out_free) begin
                r_out_vld <= r_pend;
            end
            if (accept && peek) begin
                r_pend <= 1'b1;
            end else if (out_free) begin
                r_pend <= 1'b0;
            end
        end
    end

    // payload: hold the read result until the output register frees up
    always_ff @(posedge i_clk) begin
        if (accept && peek) begin
            r_pend_none <= empty;
        end
        if (out_free && r_pend) begin
            r_out_data <= r_pend_none ? '0 : rdata;
            r_out_none <= r_pend_none;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = deq_pkg::OUT_TDATA_W'(r_out_data);
    assign o_m_tuser  = r_out_none;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("entry count above depth");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= LAST_IDX)
        else $error("front pointer out of range");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && full && (cmd == deq_pkg::CMD_PUSH_BACK || cmd == deq_pkg::CMD_PUSH_FRONT)
        |=> $stable(r_cnt) && $stable(r_front))
        else $error("push onto full store changed state");

    a_peek_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && peek |=> r_pend)
        else $error("accepted peek did not issue a read");

    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend && !out_free |=> r_pend && r_out_vld)
        else $error("pending read result lost under stall");
`endif

endmodule

### tb/sv/deq_peek_checker.sv
// Checker for the double-ended queue: tracks the ring contents from accepted commands
// and compares each peek result against the predicted one, in order.
// Depends on deq_pkg for command codes and field widths.
`timescale 1ns / 100ps

module deq_peek_checker #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [deq_pkg::IN_TDATA_W-1:0]  i_s_tdata,  // [9:0] value
    input  logic [deq_pkg::CMD_W-1:0]       i_s_tuser,  // [2:0] command
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [deq_pkg::OUT_TDATA_W-1:0] i_m_tdata,  // [9:0] peek_value
    input  logic                            i_m_tuser,  // [0] is_none
    output int                              o_pending,
    output int                              o_fail_count
);

    typedef struct packed {
        logic [deq_pkg::VALUE_W-1:0] peek_value;
        logic                        is_none;
    } t_peek;

    logic [deq_pkg::VALUE_W-1:0] ring_mem [DEPTH];
    int unsigned                 head_pos;
    int unsigned                 live_cnt;
    t_peek                       peeks_due [$];
    int                          fails = 0;

    function automatic int unsigned wrap_pos(int unsigned offs);
        int unsigned p;
        p = head_pos + offs;
        if (p >= DEPTH) p -= DEPTH;
        return p;
    endfunction

    task automatic apply_command(logic [deq_pkg::CMD_W-1:0] code,
                                 logic [deq_pkg::VALUE_W-1:0] val);
        t_peek res;
        case (code)
            deq_pkg::CMD_PUSH_BACK: begin
                if (live_cnt < DEPTH) begin
                    ring_mem[wrap_pos(live_cnt)] = val;
                    live_cnt++;
                end
            end
            deq_pkg::CMD_PUSH_FRONT: begin
                if (live_cnt < DEPTH) begin
                    head_pos = (head_pos == 0) ? DEPTH - 1 : head_pos - 1;
                    ring_mem[head_pos] = val;
                    live_cnt++;
                end
            end
            deq_pkg::CMD_PEEK_FRONT, deq_pkg::CMD_PEEK_BACK: begin
                if (live_cnt == 0) begin
                    res.peek_value = '0;
                    res.is_none    = 1'b1;
                end else begin
                    if (code == deq_pkg::CMD_PEEK_FRONT)
                        res.peek_value = ring_mem[head_pos];
                    else
                        res.peek_value = ring_mem[wrap_pos(live_cnt - 1)];
                    res.is_none    = 1'b0;
                end
                peeks_due.insert(peeks_due.size(), res);
            end
            deq_pkg::CMD_POP_BACK: begin
                if (live_cnt != 0) live_cnt--;
            end
            deq_pkg::CMD_POP_FRONT: begin
                if (live_cnt != 0) begin
                    head_pos = wrap_pos(1);
                    live_cnt--;
                end
            end
            default: ;  // unused codes change nothing
        endcase
    endtask

    always @(posedge i_clk) begin
        t_peek got;
        t_peek want;
        if (!i_rst_n) begin
            head_pos = 0;
            live_cnt = 0;
            peeks_due.delete();
        end else begin
            // retire the result first; a command accepted at this edge cannot have produced it
            if (i_m_tvalid && i_m_tready) begin
                got.peek_value = i_m_tdata[deq_pkg::VALUE_W-1:0];
                got.is_none    = i_m_tuser;
                if (peeks_due.size() == 0) begin
                    $error("unexpected result: peek_value=%0d is_none=%0b",
                           got.peek_value, got.is_none);
                    fails++;
                end else begin
                    want = peeks_due[0];
                    peeks_due.delete(0);
                    if (got.peek_value !== want.peek_value) begin
                        $error("peek_value mismatch: expected %0d, actual %0d",
                               want.peek_value, got.peek_value);
                        fails++;
                    end
                    if (got.is_none !== want.is_none) begin
                        $error("is_none mismatch: expected %0b, actual %0b",
                               want.is_none, got.is_none);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                apply_command(i_s_tuser, i_s_tdata[deq_pkg::VALUE_W-1:0]);
        end
        o_pending    <= peeks_due.size();
        o_fail_count <= fails;
    end

endmodule

### tb/sv/tb_top.sv
// Top of the double-ended queue testbench: clock, reset, command stimulus and verdict.
// Instantiates double_ended_queue and deq_peek_checker; uses deq_pkg for codes and widths.
`timescale 1ns / 100ps

module tb_top;

    localparam int          MAX_CYCLES    = 200000;
    localparam int          RX_HOLD_LEN   = 300;
    localparam int          SETTLE_CYCLES = 10;
    localparam logic [deq_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [deq_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic [deq_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [deq_pkg::CMD_W-1:0]       s_tuser  = '0;
    logic                            m_tready = 1'b0;
    logic                            s_tready;
    logic                            m_tvalid;
    logic [deq_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tuser;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          rx_hold_req = 1'b0;
    int          peeks_waiting;
    int          fail_cnt;
    int unsigned cyc = 0;

    double_ended_queue u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    deq_peek_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_pending    (peeks_waiting),
        .o_fail_count (fail_cnt)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (cyc == MAX_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver side: random stalls, plus a long hold-off on request.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = RX_HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one command; return at the edge where the transaction completes.
    task automatic send_cmd(input logic [deq_pkg::CMD_W-1:0] code,
                            input logic [deq_pkg::VALUE_W-1:0] val);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(deq_pkg::IN_TDATA_W-deq_pkg::VALUE_W){1'b0}}, val};
        s_tuser  <= code;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_random(input int push_pct, input int pop_pct, input int peek_pct);
        int                          r;
        int unsigned                 rnd;
        logic [deq_pkg::CMD_W-1:0]   code;
        logic [deq_pkg::VALUE_W-1:0] val;
        r = $urandom_range(99);
        if (r < push_pct)
            code = $urandom_range(1) ? deq_pkg::CMD_PUSH_FRONT : deq_pkg::CMD_PUSH_BACK;
        else if (r < push_pct + pop_pct)
            code = $urandom_range(1) ? deq_pkg::CMD_POP_FRONT : deq_pkg::CMD_POP_BACK;
        else if (r < push_pct + pop_pct + peek_pct)
            code = $urandom_range(1) ? deq_pkg::CMD_PEEK_FRONT : deq_pkg::CMD_PEEK_BACK;
        else
            code = $urandom_range(1) ? CMD_UNUSED_LO : CMD_UNUSED_HI;
        case ($urandom_range(9))
            0:       rnd = $urandom_range(1023, 1001);
            1:       rnd = $urandom;
            default: rnd = $urandom_range(1000, 0);
        endcase
        val = rnd[deq_pkg::VALUE_W-1:0];
        send_cmd(code, val);
    endtask

    task automatic run_phase(input int n, input int tx_pct, input int rx_pct,
                             input int push_pct, input int pop_pct, input int peek_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (n) send_random(push_pct, pop_pct, peek_pct);
    endtask

    // Hold the input idle until every predicted peek has been returned.
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (peeks_waiting != 0);
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue: peeks report none, pops and unused codes do nothing
        send_cmd(deq_pkg::CMD_PEEK_FRONT, 10'd0);
        send_cmd(deq_pkg::CMD_PEEK_BACK,  10'd0);
        send_cmd(deq_pkg::CMD_POP_BACK,   10'd0);
        send_cmd(deq_pkg::CMD_POP_FRONT,  10'd0);
        send_cmd(CMD_UNUSED_LO,           10'd0);
        send_cmd(CMD_UNUSED_HI,           10'h3FF);
        // peek right behind a push, values at both field extremes
        send_cmd(deq_pkg::CMD_PUSH_BACK,  10'd0);
        send_cmd(deq_pkg::CMD_PEEK_FRONT, 10'h3FF);
        send_cmd(deq_pkg::CMD_PEEK_BACK,  10'd0);
        send_cmd(deq_pkg::CMD_PUSH_FRONT, 10'h3FF);
        send_cmd(deq_pkg::CMD_PUSH_BACK,  10'd1000);
        send_cmd(deq_pkg::CMD_PEEK_FRONT, 10'd0);
        send_cmd(deq_pkg::CMD_PEEK_BACK,  10'd0);
        send_cmd(deq_pkg::CMD_POP_FRONT,  10'd0);
        send_cmd(deq_pkg::CMD_PEEK_FRONT, 10'd0);
        send_cmd(deq_pkg::CMD_POP_BACK,   10'd0);
        send_cmd(deq_pkg::CMD_PEEK_BACK,  10'd0);
        send_cmd(deq_pkg::CMD_PUSH_FRONT, 10'h155);
        send_cmd(deq_pkg::CMD_PUSH_BACK,  10'h2AA);
        send_cmd(deq_pkg::CMD_PEEK_FRONT, 10'd0);
        send_cmd(deq_pkg::CMD_PEEK_BACK,  10'd0);
        send_cmd(deq_pkg::CMD_POP_BACK,   10'd0);
        send_cmd(deq_pkg::CMD_POP_BACK,   10'd0);
        send_cmd(deq_pkg::CMD_POP_BACK,   10'd0);
        send_cmd(deq_pkg::CMD_PEEK_FRONT, 10'd0);

        run_phase(150, 0, 0, 40, 25, 30);
        // push-heavy: reach a full store and keep pushing into it
        run_phase(1100, 63, 0, 97, 1, 2);
        wait_results_done();

        // long receiver hold-off with peeks offered back to back
        tx_idle_pct = 0;
        rx_idle_pct = 63;
        rx_hold_req = 1'b1;
        repeat (40) send_random(0, 0, 100);
        // pop-heavy under receiver stalls
        run_phase(100, 0, 63, 3, 88, 7);
        run_phase(100, 32, 32, 40, 25, 30);

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
hdl/deq_pkg.sv
hdl/deq_store.sv
hdl/double_ended_queue.sv
tb/sv/deq_peek_checker.sv
tb/sv/tb_top.sv
